// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the priority queue RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define TLPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a sampled edge.
`define TLPQ_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlpq_pkg;

  // Entries per priority level.
  localparam int LEVEL_DEPTH = 16;
  localparam int NUM_LEVELS  = 3;

  // Result buffer depth behind the compute stage.
  localparam int OQ_DEPTH = 3;

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Priority request codes; anything else means high.
  localparam logic [1:0] PRIO_LOW = 2'd1;
  localparam logic [1:0] PRIO_MID = 2'd2;

  // Level indexes into the per-level state.
  localparam logic [1:0] LIDX_LOW  = 2'd0;
  localparam logic [1:0] LIDX_MID  = 2'd1;
  localparam logic [1:0] LIDX_HIGH = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Served level codes.
  localparam logic [1:0] LVL_NONE = 2'd0;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] served;
    logic       empty;
    logic [5:0] total;
    logic       pop_ok;
  } stage_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped;
    logic [1:0]  served;
    logic        empty;
    logic [5:0]  total;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/three_level_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------------
// in       | input     | in_valid_i/in_ready_o | cmd_i, task_value_i, priority_req_i
// out      | output    | out_valid_o/out_ready_i | status_o, popped_value_o, served_level_o,
//          |           |                       | now_empty_o, total_count_o
//
// One command per cycle while in_ready_o is high; each accepted one returns a result via stage and buffer.
// Throughput is set by the single write / single read port of the level store.
// Reset clears counts, pointers, the stage valid and the output buffer pointers;
// the level store is not cleared and needs no pass.
// Up to three results wait in the output buffer; in_ready_o drops while three are in flight.
// in_ready_o is registered and never depends on out_ready_i in the same cycle.

`include "assert_macros.svh"

module three_level_priority_queue_top #(
  parameter int LevelDepth = tlpq_pkg::LEVEL_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic signed [31:0] task_value_i,
  input  wire logic        [1:0]  priority_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] popped_value_o,
  output logic             [1:0]  served_level_o,
  output logic                    now_empty_o,
  output logic             [5:0]  total_count_o
);

  localparam int NL     = tlpq_pkg::NUM_LEVELS;
  localparam int PtrW   = $clog2(LevelDepth);
  localparam int CntW   = $clog2(LevelDepth + 1);
  localparam int AddrW  = $clog2(NL * LevelDepth);
  localparam int SumW   = $clog2(NL * LevelDepth + 1);
  localparam int TotW   = (SumW > 6) ? SumW : 6;
  localparam int OqW    = $clog2(tlpq_pkg::OQ_DEPTH);

  // Per-level FIFO bookkeeping.
  logic [CntW-1:0] cnt_q [NL];
  logic [CntW-1:0] cnt_d [NL];
  logic [PtrW-1:0] rp_q  [NL];
  logic [PtrW-1:0] rp_d  [NL];
  logic [PtrW-1:0] wp_q  [NL];
  logic [PtrW-1:0] wp_d  [NL];

  // Level store: three FIFOs laid out back to back.
  logic [31:0] mem_q [NL * LevelDepth];
  logic [31:0] rd_q;

  // Compute stage register.
  logic               s_v_q;
  tlpq_pkg::stage_t   s_q;
  tlpq_pkg::stage_t   s_d;

  // Output buffer.
  tlpq_pkg::res_t     oq_q [tlpq_pkg::OQ_DEPTH];
  tlpq_pkg::res_t     oq_in;
  logic [OqW-1:0]     oq_wp_q;
  logic [OqW-1:0]     oq_rp_q;
  logic [OqW-1:0]     q_cnt_q;
  logic [OqW-1:0]     q_cnt_d;
  logic [OqW-1:0]     occ_q;
  logic [OqW-1:0]     occ_d;

  logic               acc;
  logic               oxfer;
  logic               is_push;
  logic [NL-1:0]      push_lvl;
  logic [NL-1:0]      nonempty;
  logic [NL-1:0]      full;
  logic [NL-1:0]      pop_sel;
  logic [NL-1:0]      hit;
  logic               push_ok;
  logic               pop_ok;
  logic [1:0]         lvl_idx;
  logic [PtrW-1:0]    sel_ptr;
  logic [AddrW-1:0]   addr;
  logic [TotW-1:0]    total_d;

  // Level invariants watched by the assertions.
  logic               cnt_over;
  logic               ptr_split;

  assign acc   = in_valid_i && in_ready_o;
  assign oxfer = out_valid_o && out_ready_i;

  // Decide the command against the current counts and form next state.
  always_comb begin
    is_push = (cmd_i == tlpq_pkg::CMD_PUSH);

    // Map the requested priority to a one-hot level.
    push_lvl = '0;
    if (priority_req_i == tlpq_pkg::PRIO_LOW) begin
      push_lvl[tlpq_pkg::LIDX_LOW] = 1'b1;
    end else if (priority_req_i == tlpq_pkg::PRIO_MID) begin
      push_lvl[tlpq_pkg::LIDX_MID] = 1'b1;
    end else begin
      push_lvl[tlpq_pkg::LIDX_HIGH] = 1'b1;
    end

    for (int i = 0; i < NL; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
      full[i]     = (cnt_q[i] == CntW'(LevelDepth));
    end

    // Strict priority: high, then middle, then low.
    pop_sel = '0;
    if (nonempty[tlpq_pkg::LIDX_HIGH]) begin
      pop_sel[tlpq_pkg::LIDX_HIGH] = 1'b1;
    end else if (nonempty[tlpq_pkg::LIDX_MID]) begin
      pop_sel[tlpq_pkg::LIDX_MID] = 1'b1;
    end else if (nonempty[tlpq_pkg::LIDX_LOW]) begin
      pop_sel[tlpq_pkg::LIDX_LOW] = 1'b1;
    end

    push_ok = is_push && |(push_lvl & ~full);
    pop_ok  = !is_push && |nonempty;
    hit     = is_push ? (push_lvl & ~full) : pop_sel;

    if (hit[tlpq_pkg::LIDX_HIGH]) begin
      lvl_idx = tlpq_pkg::LIDX_HIGH;
    end else if (hit[tlpq_pkg::LIDX_MID]) begin
      lvl_idx = tlpq_pkg::LIDX_MID;
    end else begin
      lvl_idx = tlpq_pkg::LIDX_LOW;
    end

    // Advance the touched level only.
    for (int i = 0; i < NL; i++) begin
      cnt_d[i] = cnt_q[i];
      rp_d[i]  = rp_q[i];
      wp_d[i]  = wp_q[i];
      if (acc && hit[i]) begin
        if (is_push) begin
          cnt_d[i] = cnt_q[i] + CntW'(1);
          wp_d[i]  = (wp_q[i] == PtrW'(LevelDepth - 1)) ? '0 : wp_q[i] + PtrW'(1);
        end else begin
          cnt_d[i] = cnt_q[i] - CntW'(1);
          rp_d[i]  = (rp_q[i] == PtrW'(LevelDepth - 1)) ? '0 : rp_q[i] + PtrW'(1);
        end
      end
    end

    case (lvl_idx)
      tlpq_pkg::LIDX_LOW:  sel_ptr = is_push ? wp_q[0] : rp_q[0];
      tlpq_pkg::LIDX_MID:  sel_ptr = is_push ? wp_q[1] : rp_q[1];
      tlpq_pkg::LIDX_HIGH: sel_ptr = is_push ? wp_q[2] : rp_q[2];
      default:             sel_ptr = '0;
    endcase

    addr = AddrW'(lvl_idx) * AddrW'(LevelDepth) + AddrW'(sel_ptr);

    total_d = TotW'(cnt_d[0]) + TotW'(cnt_d[1]) + TotW'(cnt_d[2]);

    // Status and served level for the result.
    if (is_push) begin
      s_d.status = push_ok ? tlpq_pkg::STAT_OK : tlpq_pkg::STAT_FULL;
    end else begin
      s_d.status = pop_ok ? tlpq_pkg::STAT_OK : tlpq_pkg::STAT_EMPTY;
    end
    s_d.served = (push_ok || pop_ok) ? lvl_idx + 2'd1 : tlpq_pkg::LVL_NONE;
    s_d.empty  = (total_d == '0);
    s_d.total  = total_d[5:0];
    s_d.pop_ok = pop_ok;
  end

  // Level store: write on push, registered read on pop.
  always_ff @(posedge clk_i) begin
    if (acc && push_ok) begin
      mem_q[addr] <= $unsigned(task_value_i);
    end
    if (acc && pop_ok) begin
      rd_q <= mem_q[addr];
    end
  end

  // Per-level counts and pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) begin
        cnt_q[i] <= '0;
        rp_q[i]  <= '0;
        wp_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NL; i++) begin
        cnt_q[i] <= cnt_d[i];
        rp_q[i]  <= rp_d[i];
        wp_q[i]  <= wp_d[i];
      end
    end
  end

  // Compute stage: holds one result for exactly one cycle, then drains into the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else begin
      s_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s_q <= s_d;
    end
  end

  // Merge the store read data into the result.
  always_comb begin
    oq_in.status = s_q.status;
    oq_in.popped = s_q.pop_ok ? rd_q : '0;
    oq_in.served = s_q.served;
    oq_in.empty  = s_q.empty;
    oq_in.total  = s_q.total;
  end

  // Output buffer: occupancy counts every transaction in flight, stage included.
  always_comb begin
    occ_d   = occ_q + OqW'(acc) - OqW'(oxfer);
    q_cnt_d = q_cnt_q + OqW'(s_v_q) - OqW'(oxfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      q_cnt_q    <= '0;
      oq_wp_q    <= '0;
      oq_rp_q    <= '0;
      in_ready_o <= 1'b0;
    end else begin
      occ_q      <= occ_d;
      q_cnt_q    <= q_cnt_d;
      in_ready_o <= (occ_d != OqW'(tlpq_pkg::OQ_DEPTH));
      if (s_v_q) begin
        oq_wp_q <= (oq_wp_q == OqW'(tlpq_pkg::OQ_DEPTH - 1)) ? '0 : oq_wp_q + OqW'(1);
      end
      if (oxfer) begin
        oq_rp_q <= (oq_rp_q == OqW'(tlpq_pkg::OQ_DEPTH - 1)) ? '0 : oq_rp_q + OqW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_v_q) begin
      oq_q[oq_wp_q] <= oq_in;
    end
  end

  assign out_valid_o    = (q_cnt_q != '0);
  assign status_o       = oq_q[oq_rp_q].status;
  assign popped_value_o = $signed(oq_q[oq_rp_q].popped);
  assign served_level_o = oq_q[oq_rp_q].served;
  assign now_empty_o    = oq_q[oq_rp_q].empty;
  assign total_count_o  = oq_q[oq_rp_q].total;

  // Flag a level over its depth, or an empty level whose pointers differ.
  always_comb begin
    cnt_over  = 1'b0;
    ptr_split = 1'b0;
    for (int i = 0; i < NL; i++) begin
      cnt_over  = cnt_over || (cnt_q[i] > CntW'(LevelDepth));
      ptr_split = ptr_split || ((cnt_q[i] == '0) && (rp_q[i] != wp_q[i]));
    end
  end

  // Buffered results never outnumber the transactions in flight.
  `TLPQ_ASSERT(a_qcnt_le_occ, q_cnt_q <= occ_q, "output buffer exceeds in-flight count")
  // A successful pop reaches the stage with its read data flagged.
  `TLPQ_ASSERT(a_pop_staged, acc && pop_ok |=> s_v_q && s_q.pop_ok, "pop lost before stage")
  // No level holds more than its depth.
  `TLPQ_ASSERT_NEVER(a_cnt_over, cnt_over, "level count over depth")
  // An empty level has its pointers together.
  `TLPQ_ASSERT_NEVER(a_empty_ptrs, ptr_split, "empty level with split pointers")

endmodule

`default_nettype wire

// ===== verif/three_level_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps

module three_level_priority_queue_top_tb;

  // A clocked driver feeds transactions from a backlog that the initial block fills.
  // A clocked monitor predicts each accepted command and checks every result
  // against the oldest prediction still waiting.

  // Bound the run well above the slowest correct one: about 550 commands,
  // with both sides idling at random.
  localparam int CycleLimit = 20000;
  localparam int RandomItems = 520;
  // Drain time after the last result.
  localparam int TailCycles = 10;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] value;
    logic        [1:0]  prio;
  } queue_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cmd_i = tlpq_pkg::CMD_PUSH;
  logic signed [31:0] task_value_i = '0;
  logic        [1:0]  priority_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic        [1:0]  status_o;
  logic signed [31:0] popped_value_o;
  logic        [1:0]  served_level_o;
  logic               now_empty_o;
  logic        [5:0]  total_count_o;

  queue_cmd_t      cmd_backlog[$];
  queue_cmd_t      next_cmd;
  tlpq_pkg::res_t  expected_results[$];
  tlpq_pkg::res_t  predicted;
  tlpq_pkg::res_t  oldest_result;
  int              mismatch_count = 0;
  int              cycle_count = 0;

  // Shadow state of the three level FIFOs.
  logic signed [31:0] level_mem[tlpq_pkg::NUM_LEVELS][tlpq_pkg::LEVEL_DEPTH];
  int                 head_idx[tlpq_pkg::NUM_LEVELS];
  int                 tail_idx[tlpq_pkg::NUM_LEVELS];
  int                 fill_level[tlpq_pkg::NUM_LEVELS];

  // Long stretch where neither side idles.
  wire steady_phase = (cycle_count >= 200) && (cycle_count < 450);

  three_level_priority_queue_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .task_value_i   (task_value_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .served_level_o (served_level_o),
    .now_empty_o    (now_empty_o),
    .total_count_o  (total_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one command to the shadow queue and return the result it causes.
  function automatic tlpq_pkg::res_t serve_command(logic cmd, logic signed [31:0] value,
                                                   logic [1:0] prio);
    tlpq_pkg::res_t outcome;
    int   lvl;
    int   total;
    outcome = '0;
    outcome.status = tlpq_pkg::STAT_OK;
    outcome.served = tlpq_pkg::LVL_NONE;
    if (cmd == tlpq_pkg::CMD_PUSH) begin
      // Priority 1 is low, 2 is middle; 0 and 3 both land in high.
      if (prio == tlpq_pkg::PRIO_LOW) lvl = tlpq_pkg::LIDX_LOW;
      else if (prio == tlpq_pkg::PRIO_MID) lvl = tlpq_pkg::LIDX_MID;
      else lvl = tlpq_pkg::LIDX_HIGH;
      if (fill_level[lvl] >= tlpq_pkg::LEVEL_DEPTH) begin
        outcome.status = tlpq_pkg::STAT_FULL;
      end else begin
        level_mem[lvl][tail_idx[lvl]] = value;
        tail_idx[lvl] = (tail_idx[lvl] + 1) % tlpq_pkg::LEVEL_DEPTH;
        fill_level[lvl]++;
        outcome.served = 2'(lvl + 1);
      end
    end else begin
      // Scan high, then middle, then low.
      lvl = -1;
      if (fill_level[tlpq_pkg::LIDX_HIGH] != 0) lvl = tlpq_pkg::LIDX_HIGH;
      else if (fill_level[tlpq_pkg::LIDX_MID] != 0) lvl = tlpq_pkg::LIDX_MID;
      else if (fill_level[tlpq_pkg::LIDX_LOW] != 0) lvl = tlpq_pkg::LIDX_LOW;
      if (lvl < 0) begin
        outcome.status = tlpq_pkg::STAT_EMPTY;
      end else begin
        outcome.popped = level_mem[lvl][head_idx[lvl]];
        head_idx[lvl] = (head_idx[lvl] + 1) % tlpq_pkg::LEVEL_DEPTH;
        fill_level[lvl]--;
        outcome.served = 2'(lvl + 1);
      end
    end
    total = fill_level[0] + fill_level[1] + fill_level[2];
    outcome.empty = (total == 0);
    outcome.total = 6'(total);
    return outcome;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  function automatic void add_cmd(logic cmd, logic [31:0] value, logic [1:0] prio);
    queue_cmd_t entry;
    entry.cmd = cmd;
    entry.value = value;
    entry.prio = prio;
    cmd_backlog = {cmd_backlog, entry};
  endfunction

  // Driver: hold valid and payload until the transaction is taken, then
  // advance to the next command or idle at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (cmd_backlog.size() != 0 && (steady_phase || $urandom_range(99) >= 10)) begin
        next_cmd = cmd_backlog.pop_front();
        in_valid_i     <= 1'b1;
        cmd_i          <= next_cmd.cmd;
        task_value_i   <= next_cmd.value;
        priority_req_i <= next_cmd.prio;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side about ten percent of the time, except in the steady stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= steady_phase || ($urandom_range(99) >= 10);
  end

  // Monitor: predict on input transactions first, so that a result leaving
  // on the same edge still finds its prediction, then check the result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = serve_command(cmd_i, task_value_i, priority_req_i);
        expected_results = {expected_results, predicted};
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no command waiting: status %0d value 0x%0h",
                 status_o, popped_value_o);
          mismatch_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          compare_field("status", 32'(oldest_result.status), 32'(status_o));
          compare_field("popped_value", oldest_result.popped, popped_value_o);
          compare_field("served_level", 32'(oldest_result.served), 32'(served_level_o));
          compare_field("now_empty", 32'(oldest_result.empty), 32'(now_empty_o));
          compare_field("total_count", 32'(oldest_result.total), 32'(total_count_o));
        end
      end
    end
  end

  // Watchdog: end the run as failed once cycle_count reaches CycleLimit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int burst_len;
    int push_pct;
    int mode;
    bit one_level;
    logic [1:0] focus_prio;
    logic [1:0] prio;

    for (int l = 0; l < tlpq_pkg::NUM_LEVELS; l++) begin
      head_idx[l] = 0;
      tail_idx[l] = 0;
      fill_level[l] = 0;
    end

    // Directed part: pop on an empty queue, extreme values on every
    // priority code, strict ordering across levels, then empty again.
    add_cmd(tlpq_pkg::CMD_POP, 32'hFFFF_FFFF, 2'd3);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'h7FFF_FFFF, tlpq_pkg::PRIO_LOW);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'h8000_0000, tlpq_pkg::PRIO_MID);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'h0000_0000, 2'd0);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 2'd3);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'h0000_0001, tlpq_pkg::PRIO_LOW);
    for (int i = 0; i < 5; i++) add_cmd(tlpq_pkg::CMD_POP, 32'h0, 2'd0);
    add_cmd(tlpq_pkg::CMD_POP, 32'h1234_5678, tlpq_pkg::PRIO_MID);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'h5555_5555, tlpq_pkg::PRIO_LOW);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'hAAAA_AAAA, tlpq_pkg::PRIO_MID);
    add_cmd(tlpq_pkg::CMD_POP, 32'h0, tlpq_pkg::PRIO_LOW);
    add_cmd(tlpq_pkg::CMD_PUSH, 32'h1234_5678, 2'd3);
    add_cmd(tlpq_pkg::CMD_POP, 32'h0, 2'd0);
    add_cmd(tlpq_pkg::CMD_POP, 32'h0, 2'd0);
    add_cmd(tlpq_pkg::CMD_POP, 32'h0, 2'd0);

    // Random part in bursts: push-heavy bursts fill levels to the refusal
    // point and wrap the pointers, pop-heavy bursts drain to empty.
    for (int b = 0; cmd_backlog.size() < RandomItems; b++) begin
      burst_len = $urandom_range(60, 15);
      mode = (b == 0) ? 0 : (b == 1) ? 1 : $urandom_range(2);
      if (b == 0) burst_len = 70;
      push_pct = (mode == 0) ? 85 : (mode == 1) ? 20 : 50;
      one_level = ($urandom_range(3) == 0);
      focus_prio = 2'($urandom_range(3));
      for (int i = 0; i < burst_len; i++) begin
        prio = one_level ? focus_prio : 2'($urandom_range(3));
        // Pops carry random payload too; the block must ignore it.
        add_cmd(($urandom_range(99) < push_pct) ? tlpq_pkg::CMD_PUSH : tlpq_pkg::CMD_POP,
                $urandom, prio);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== three_level_priority_queue_top.f =====
+incdir+hw/rtl
hw/rtl/tlpq_pkg.sv
hw/rtl/three_level_priority_queue_top.sv
verif/three_level_priority_queue_top_tb.sv
